FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Assertion on the standard clk_i / rst_ni pair
`define ASSERT_STD(lbl, prop, msg) \
  `ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: sv/lkfr_pkg.sv
// ----------------------------------------------------------------------------
// LRU-K frame replacer package
// Widths, reset values, codes and state types shared by the replacer files.
// ----------------------------------------------------------------------------
package lkfr_pkg;

  // Default frame count of the table
  localparam int unsigned MAX_FRAMES_DEF = 16;

  // Field widths of the channels
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned FRAME_W    = 4;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned VICTIM_W   = 4;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  // Per-frame access count and register widths
  localparam int unsigned HIT_W  = 4;
  localparam int unsigned KTH_W  = 4;
  localparam int unsigned HCAP_W = 5;

  localparam logic [HIT_W-1:0]  HIT_MAX  = '1;
  localparam logic [KTH_W-1:0]  KTH_RST  = 4'd2;
  localparam logic [HCAP_W-1:0] HCAP_RST = 5'd16;

  // Request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ACCESS = 2'd0,
    KIND_SET    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_EVICT  = 2'd3
  } kind_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_NONE      = 3'd1,
    STAT_UNKNOWN   = 3'd2,
    STAT_NOT_EVICT = 3'd3,
    STAT_HIST_FULL = 3'd4
  } status_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_K_THRESHOLD = 2'd0,
    CFG_HIST_CAP    = 2'd1
  } cfg_reg_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_DECIDE,
    S_UPDATE,
    S_UPD_END,
    S_DONE
  } fsm_e;

  // Table rewrite action chosen after the scan
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_INSERT,
    ACT_PROMOTE,
    ACT_DROP
  } act_e;

endpackage

FILE: sv/lkfr_if.sv
// ----------------------------------------------------------------------------
// LRU-K frame replacer channels
// Valid/ready interfaces for request, result and configuration beats.
// ----------------------------------------------------------------------------

// Request channel
interface lkfr_req_if;
  logic                        valid;
  logic                        ready;
  logic [lkfr_pkg::KIND_W-1:0]  kind;
  logic [lkfr_pkg::FRAME_W-1:0] frame;
  logic                        evictable_flag;

  modport source (output valid, kind, frame, evictable_flag, input ready);
  modport sink   (input valid, kind, frame, evictable_flag, output ready);
endinterface

// Result channel
interface lkfr_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lkfr_pkg::STATUS_W-1:0] status;
  logic [lkfr_pkg::VICTIM_W-1:0] victim;
  logic [lkfr_pkg::COUNT_W-1:0]  evictable_count;

  modport source (output valid, status, victim, evictable_count, input ready);
  modport sink   (input valid, status, victim, evictable_count, output ready);
endinterface

// Configuration write channel
interface lkfr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lkfr_pkg::CFG_IDX_W-1:0]  index;
  logic [lkfr_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/lkfr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lkfr_ram #(
  parameter  int unsigned Width = 8,
  parameter  int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/lru_k_frame_replacer_unit.sv
// ----------------------------------------------------------------------------
// LRU-K frame replacer
// Tracks up to MAX_FRAMES buffer frames and picks eviction victims: frames
// with fewer than k_threshold accesses (history class) go first, least
// recently accessed first, then cache-class frames in the same order. Each
// request beat gives exactly one result beat. One request is handled at a
// time: the per-frame table (evictable flag, access count, recency rank) sits
// in a RAM that a small sequencer walks one entry per cycle. Every request
// first scans all MAX_FRAMES entries; a successful access, remove or evict
// then walks the table a second time to rewrite ranks. The next request is
// taken once the result sits in the output register. Tracked bits are
// flip-flops cleared by reset, so no clearing pass is run. Configuration
// writes are always accepted and must only come while idle.
// ----------------------------------------------------------------------------
module lru_k_frame_replacer_unit #(
  parameter int unsigned MAX_FRAMES = lkfr_pkg::MAX_FRAMES_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  lkfr_req_if.sink    req_i,
  lkfr_rsp_if.source  rsp_o,
  lkfr_cfg_if.sink    cfg_i
);

  localparam int unsigned FW  = $clog2(MAX_FRAMES);
  localparam int unsigned CW  = $clog2(MAX_FRAMES + 1);
  localparam int unsigned HW  = lkfr_pkg::HIT_W;
  localparam int unsigned VW  = lkfr_pkg::VICTIM_W;
  localparam int unsigned OW  = lkfr_pkg::COUNT_W;
  localparam int unsigned EW  = 1 + HW + FW;
  localparam logic [FW-1:0] LAST_IDX = FW'(MAX_FRAMES - 1);

  typedef struct packed {
    logic          ev;
    logic [HW-1:0] hit;
    logic [FW-1:0] rank;
  } entry_t;

  // Configuration registers
  logic [lkfr_pkg::KTH_W-1:0]  k_q;
  logic [lkfr_pkg::HCAP_W-1:0] hcap_q;

  // Sequencer
  lkfr_pkg::fsm_e state_q, state_d;
  logic [FW-1:0]  addr_q;
  logic           rd_vld_q;
  logic [FW-1:0]  rd_idx_q;

  // Captured request
  lkfr_pkg::kind_e              kind_q;
  logic [lkfr_pkg::FRAME_W-1:0] frame_q;
  logic                         flag_q;

  // Scan results
  logic [HW-1:0] tgt_hit_q;
  logic [FW-1:0] tgt_rank_q;
  logic          tgt_ev_q;
  logic [CW-1:0] hist_q;
  logic          hb_vld_q, cb_vld_q;
  logic [FW-1:0] hb_idx_q, hb_rank_q, cb_idx_q, cb_rank_q;

  // Table state outside the RAM
  logic [MAX_FRAMES-1:0] tracked_q;
  logic [CW-1:0]         cnt_q, cnt_d;

  // Decision
  lkfr_pkg::act_e    act_q, act_d;
  lkfr_pkg::status_e stat_q, stat_d;
  logic [VW-1:0]     vic_q, vic_d;
  logic [FW-1:0]     tgt_q, tgt_d;
  logic [FW-1:0]     ref_q, ref_d;
  logic              set_we;

  // Result register
  logic                       rsp_vld_q;
  logic [lkfr_pkg::STATUS_W-1:0] rsp_stat_q;
  logic [VW-1:0]              rsp_vic_q;
  logic [OW-1:0]              rsp_cnt_q;

  // Control strobes
  logic req_acc, ram_re, decide_en, rsp_load, scan_en, upd_en;

  // RAM ports
  logic          ram_we;
  logic [FW-1:0] ram_waddr;
  entry_t        ram_wdata, rd_ent, upd_ent;
  logic [EW-1:0] ram_rdata;
  logic          upd_we;

  logic          frame_ok;
  logic [FW-1:0] f_idx;
  logic          tgt_tracked;
  logic          rd_cache;
  logic [HW-1:0] hit_inc;

  assign frame_ok    = (32'(frame_q) < MAX_FRAMES);
  assign f_idx       = FW'(frame_q);
  assign tgt_tracked = tracked_q[f_idx];
  assign req_acc     = req_i.valid && req_i.ready;
  assign rd_ent      = entry_t'(ram_rdata);
  assign rd_cache    = (rd_ent.hit >= k_q);
  assign hit_inc     = (rd_ent.hit == lkfr_pkg::HIT_MAX) ? rd_ent.hit : rd_ent.hit + HW'(1);

  // Configuration writes, always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= lkfr_pkg::KTH_RST;
      hcap_q <= lkfr_pkg::HCAP_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (lkfr_pkg::cfg_reg_e'(cfg_i.index))
        lkfr_pkg::CFG_K_THRESHOLD: k_q    <= cfg_i.data[lkfr_pkg::KTH_W-1:0];
        lkfr_pkg::CFG_HIST_CAP:    hcap_q <= cfg_i.data[lkfr_pkg::HCAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lkfr_pkg::S_IDLE:     if (req_acc) state_d = lkfr_pkg::S_SCAN;
      lkfr_pkg::S_SCAN:     if (addr_q == LAST_IDX) state_d = lkfr_pkg::S_SCAN_END;
      lkfr_pkg::S_SCAN_END: state_d = lkfr_pkg::S_DECIDE;
      lkfr_pkg::S_DECIDE: begin
        state_d = (act_d != lkfr_pkg::ACT_NONE) ? lkfr_pkg::S_UPDATE : lkfr_pkg::S_DONE;
      end
      lkfr_pkg::S_UPDATE:   if (addr_q == LAST_IDX) state_d = lkfr_pkg::S_UPD_END;
      lkfr_pkg::S_UPD_END:  state_d = lkfr_pkg::S_DONE;
      lkfr_pkg::S_DONE:     if (!rsp_vld_q || rsp_o.ready) state_d = lkfr_pkg::S_IDLE;
      default:              state_d = lkfr_pkg::S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    req_i.ready = (state_q == lkfr_pkg::S_IDLE);
    ram_re      = (state_q == lkfr_pkg::S_SCAN) || (state_q == lkfr_pkg::S_UPDATE);
    scan_en     = rd_vld_q &&
                  ((state_q == lkfr_pkg::S_SCAN) || (state_q == lkfr_pkg::S_SCAN_END));
    upd_en      = rd_vld_q &&
                  ((state_q == lkfr_pkg::S_UPDATE) || (state_q == lkfr_pkg::S_UPD_END));
    decide_en   = (state_q == lkfr_pkg::S_DECIDE);
    rsp_load    = (state_q == lkfr_pkg::S_DONE) && (!rsp_vld_q || rsp_o.ready);
  end

  // Sequencer registers and table walk address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lkfr_pkg::S_IDLE;
      addr_q   <= '0;
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= ram_re;
      rd_idx_q <= addr_q;
      if (ram_re) begin
        addr_q <= (addr_q == LAST_IDX) ? '0 : addr_q + FW'(1);
      end
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      kind_q  <= lkfr_pkg::kind_e'(req_i.kind);
      frame_q <= req_i.frame;
      flag_q  <= req_i.evictable_flag;
    end
  end

  // Scan pass: target entry, history count, oldest evictable per class
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_hit_q  <= '0;
      tgt_rank_q <= '0;
      tgt_ev_q   <= 1'b0;
      hist_q     <= '0;
      hb_vld_q   <= 1'b0;
      hb_idx_q   <= '0;
      hb_rank_q  <= '0;
      cb_vld_q   <= 1'b0;
      cb_idx_q   <= '0;
      cb_rank_q  <= '0;
    end else if (req_acc) begin
      hist_q   <= '0;
      hb_vld_q <= 1'b0;
      cb_vld_q <= 1'b0;
    end else if (scan_en) begin
      if (rd_idx_q == f_idx) begin
        tgt_hit_q  <= rd_ent.hit;
        tgt_rank_q <= rd_ent.rank;
        tgt_ev_q   <= rd_ent.ev;
      end
      if (tracked_q[rd_idx_q] && !rd_cache) begin
        hist_q <= hist_q + CW'(1);
      end
      if (tracked_q[rd_idx_q] && rd_ent.ev && !rd_cache &&
          (!hb_vld_q || (rd_ent.rank > hb_rank_q))) begin
        hb_vld_q  <= 1'b1;
        hb_idx_q  <= rd_idx_q;
        hb_rank_q <= rd_ent.rank;
      end
      if (tracked_q[rd_idx_q] && rd_ent.ev && rd_cache &&
          (!cb_vld_q || (rd_ent.rank > cb_rank_q))) begin
        cb_vld_q  <= 1'b1;
        cb_idx_q  <= rd_idx_q;
        cb_rank_q <= rd_ent.rank;
      end
    end
  end

  // Decision from the scan results
  always_comb begin
    act_d  = lkfr_pkg::ACT_NONE;
    stat_d = lkfr_pkg::STAT_OK;
    vic_d  = '0;
    tgt_d  = f_idx;
    ref_d  = tgt_rank_q;
    cnt_d  = cnt_q;
    set_we = 1'b0;
    if (kind_q == lkfr_pkg::KIND_EVICT) begin
      if (hb_vld_q || cb_vld_q) begin
        act_d = lkfr_pkg::ACT_DROP;
        tgt_d = hb_vld_q ? hb_idx_q : cb_idx_q;
        ref_d = hb_vld_q ? hb_rank_q : cb_rank_q;
        vic_d = VW'(tgt_d);
        if (cnt_q != '0) cnt_d = cnt_q - CW'(1);
      end else begin
        stat_d = lkfr_pkg::STAT_NONE;
      end
    end else if (!frame_ok) begin
      stat_d = lkfr_pkg::STAT_UNKNOWN;
    end else if (kind_q == lkfr_pkg::KIND_ACCESS) begin
      if (tgt_tracked) begin
        act_d = lkfr_pkg::ACT_PROMOTE;
      end else if (32'(hist_q) >= 32'(hcap_q)) begin
        stat_d = lkfr_pkg::STAT_HIST_FULL;
      end else begin
        act_d = lkfr_pkg::ACT_INSERT;
        cnt_d = cnt_q + CW'(1);
      end
    end else if (kind_q == lkfr_pkg::KIND_SET) begin
      if (!tgt_tracked) begin
        stat_d = lkfr_pkg::STAT_UNKNOWN;
      end else if (tgt_ev_q && !flag_q) begin
        set_we = 1'b1;
        if (cnt_q != '0) cnt_d = cnt_q - CW'(1);
      end else if (!tgt_ev_q && flag_q) begin
        set_we = 1'b1;
        cnt_d  = cnt_q + CW'(1);
      end
    end else if (tgt_tracked) begin
      // remove
      if (!tgt_ev_q) begin
        stat_d = lkfr_pkg::STAT_NOT_EVICT;
      end else begin
        act_d = lkfr_pkg::ACT_DROP;
        if (cnt_q != '0) cnt_d = cnt_q - CW'(1);
      end
    end
  end

  // Decision registers, tracked bits and evictable count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= lkfr_pkg::ACT_NONE;
      stat_q    <= lkfr_pkg::STAT_OK;
      vic_q     <= '0;
      tgt_q     <= '0;
      ref_q     <= '0;
      cnt_q     <= '0;
      tracked_q <= '0;
    end else if (decide_en) begin
      act_q  <= act_d;
      stat_q <= stat_d;
      vic_q  <= vic_d;
      tgt_q  <= tgt_d;
      ref_q  <= ref_d;
      cnt_q  <= cnt_d;
      if (act_d == lkfr_pkg::ACT_INSERT) tracked_q[tgt_d] <= 1'b1;
      if (act_d == lkfr_pkg::ACT_DROP)   tracked_q[tgt_d] <= 1'b0;
    end
  end

  // Update pass: rewrite ranks, target entry gets its new contents
  always_comb begin
    upd_we  = 1'b0;
    upd_ent = rd_ent;
    if (rd_idx_q == tgt_q) begin
      upd_ent.rank = '0;
      case (act_q)
        lkfr_pkg::ACT_INSERT: begin
          upd_we      = 1'b1;
          upd_ent.ev  = 1'b1;
          upd_ent.hit = HW'(1);
        end
        lkfr_pkg::ACT_PROMOTE: begin
          upd_we      = 1'b1;
          upd_ent.hit = hit_inc;
        end
        default: ;
      endcase
    end else if (tracked_q[rd_idx_q]) begin
      upd_we = 1'b1;
      case (act_q)
        lkfr_pkg::ACT_INSERT:  upd_ent.rank = rd_ent.rank + FW'(1);
        lkfr_pkg::ACT_PROMOTE: begin
          if (rd_ent.rank < ref_q) upd_ent.rank = rd_ent.rank + FW'(1);
        end
        lkfr_pkg::ACT_DROP: begin
          if (rd_ent.rank > ref_q) upd_ent.rank = rd_ent.rank - FW'(1);
        end
        default: upd_we = 1'b0;
      endcase
    end
  end

  // RAM write selection: flag change at decide, rank rewrite during update
  always_comb begin
    ram_we    = (set_we && decide_en) || (upd_we && upd_en);
    ram_waddr = decide_en ? f_idx : rd_idx_q;
    if (decide_en) begin
      ram_wdata.ev   = flag_q;
      ram_wdata.hit  = tgt_hit_q;
      ram_wdata.rank = tgt_rank_q;
    end else begin
      ram_wdata = upd_ent;
    end
  end

  lkfr_ram #(
    .Width (EW),
    .Depth (MAX_FRAMES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (rsp_load) begin
      rsp_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_stat_q <= stat_q;
      rsp_vic_q  <= vic_q;
      rsp_cnt_q  <= OW'(cnt_q);
    end
  end

  assign rsp_o.valid           = rsp_vld_q;
  assign rsp_o.status          = rsp_stat_q;
  assign rsp_o.victim          = rsp_vic_q;
  assign rsp_o.evictable_count = rsp_cnt_q;

endmodule

FILE: sv/lkfr_checker.sv
// ----------------------------------------------------------------------------
// LRU-K frame replacer checker
// Port-level assertions on the replacer, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lkfr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [lkfr_pkg::STATUS_W-1:0] rsp_status_i,
  input logic [lkfr_pkg::VICTIM_W-1:0] rsp_victim_i,
  input logic [lkfr_pkg::COUNT_W-1:0]  rsp_count_i
);

  // Only defined status codes leave the block
  `ASSERT_STD(a_status_code, rsp_valid_i |-> (rsp_status_i <= lkfr_pkg::STAT_HIST_FULL), "undefined status code")

  // A victim is named only by a successful beat
  `ASSERT_STD(a_victim_zero, (rsp_valid_i && (rsp_status_i != lkfr_pkg::STAT_OK)) |-> (rsp_victim_i == '0), "victim set on failed request")

  // Nothing evictable means an evictable count of zero
  `ASSERT_STD(a_none_count, (rsp_valid_i && (rsp_status_i == lkfr_pkg::STAT_NONE)) |-> (rsp_count_i == '0), "none evictable with nonzero count")

  // One request at a time: no new beat right after an accept
  `ASSERT_STD(a_one_inflight, (req_valid_i && req_ready_i) |=> !req_ready_i, "request accepted back to back")

  // A stalled result beat holds
  `ASSERT_STD(a_rsp_hold, (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_victim_i) && $stable(rsp_count_i)), "stalled result changed")

endmodule

bind lru_k_frame_replacer_unit lkfr_checker u_lkfr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_victim_i (rsp_o.victim),
  .rsp_count_i  (rsp_o.evictable_count)
);

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// LRU-K frame replacer testbench
// Drives request beats into the replacer and checks each result beat against
// a cycle-free model of the frame table kept here, or against the row's own
// values for fixed rows of a short directed table that comes first; random
// requests then run under several register settings and several idle patterns on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int unsigned NFR         = lkfr_pkg::MAX_FRAMES_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SEG_ITEMS   = 95;
  localparam int unsigned NUM_SEGS    = 9;
  localparam int unsigned FRM_W       = lkfr_pkg::FRAME_W;
  localparam int unsigned VIC_W       = lkfr_pkg::VICTIM_W;
  localparam int unsigned CNT_W       = lkfr_pkg::COUNT_W;
  localparam int unsigned HT_W        = lkfr_pkg::HIT_W;
  localparam int unsigned K_W         = lkfr_pkg::KTH_W;
  localparam int unsigned CAP_W       = lkfr_pkg::HCAP_W;

  // One result beat as the block should return it
  typedef struct packed {
    lkfr_pkg::status_e status;
    logic [VIC_W-1:0]  victim;
    logic [CNT_W-1:0]  count;
  } outcome_t;

  // Directed step: optional register write, then one request
  typedef struct packed {
    bit                wr_regs;
    logic [K_W-1:0]    k_val;
    logic [CAP_W-1:0]  cap_val;
    lkfr_pkg::kind_e   kind;
    logic [FRM_W-1:0]  frame;
    bit                flag;
    bit                fixed;
    lkfr_pkg::status_e st;
    logic [VIC_W-1:0]  vic;
    logic [CNT_W-1:0]  cnt;
  } step_row_t;

  localparam step_row_t PLAN [25] = '{
    '{0, 0, 0, lkfr_pkg::KIND_EVICT,   0, 0, 1, lkfr_pkg::STAT_NONE,      0, 0},  // empty
    '{0, 0, 0, lkfr_pkg::KIND_SET,    15, 1, 1, lkfr_pkg::STAT_UNKNOWN,   0, 0},  // unknown
    '{0, 0, 0, lkfr_pkg::KIND_REMOVE,  0, 0, 1, lkfr_pkg::STAT_OK,        0, 0},  // unknown
    '{0, 0, 0, lkfr_pkg::KIND_ACCESS,  0, 0, 1, lkfr_pkg::STAT_OK,        0, 1},  // new
    '{0, 0, 0, lkfr_pkg::KIND_ACCESS, 15, 0, 1, lkfr_pkg::STAT_OK,        0, 2},
    '{0, 0, 0, lkfr_pkg::KIND_ACCESS,  0, 0, 0, lkfr_pkg::STAT_OK,        0, 0},  // to cache
    '{0, 0, 0, lkfr_pkg::KIND_SET,    15, 0, 0, lkfr_pkg::STAT_OK,        0, 0},
    '{0, 0, 0, lkfr_pkg::KIND_SET,    15, 0, 0, lkfr_pkg::STAT_OK,        0, 0},  // same
    '{0, 0, 0, lkfr_pkg::KIND_REMOVE, 15, 0, 1, lkfr_pkg::STAT_NOT_EVICT, 0, 1},
    '{0, 0, 0, lkfr_pkg::KIND_EVICT,   0, 0, 0, lkfr_pkg::STAT_OK,        0, 0},  // cache
    '{0, 0, 0, lkfr_pkg::KIND_EVICT,   0, 0, 1, lkfr_pkg::STAT_NONE,      0, 0},  // pinned
    '{0, 0, 0, lkfr_pkg::KIND_SET,    15, 1, 0, lkfr_pkg::STAT_OK,        0, 0},
    '{0, 0, 0, lkfr_pkg::KIND_ACCESS,  7, 1, 0, lkfr_pkg::STAT_OK,        0, 0},
    '{0, 0, 0, lkfr_pkg::KIND_EVICT,   0, 0, 0, lkfr_pkg::STAT_OK,        0, 0},  // oldest
    '{1, 0, 0, lkfr_pkg::KIND_ACCESS,  9, 0, 1, lkfr_pkg::STAT_HIST_FULL, 0, 1},  // cap 0
    '{0, 0, 0, lkfr_pkg::KIND_ACCESS,  7, 0, 0, lkfr_pkg::STAT_OK,        0, 0},
    '{0, 0, 0, lkfr_pkg::KIND_EVICT,   0, 0, 0, lkfr_pkg::STAT_OK,        0, 0},
    '{1, 15, 1, lkfr_pkg::KIND_ACCESS, 4, 0, 0, lkfr_pkg::STAT_OK,        0, 0},
    '{0, 0, 0, lkfr_pkg::KIND_ACCESS,  5, 0, 1, lkfr_pkg::STAT_HIST_FULL, 0, 1},  // full
    '{0, 0, 0, lkfr_pkg::KIND_ACCESS,  4, 0, 0, lkfr_pkg::STAT_OK,        0, 0},
    '{1, 1, 16, lkfr_pkg::KIND_ACCESS, 5, 0, 0, lkfr_pkg::STAT_OK,        0, 0},  // all cache
    '{0, 0, 0, lkfr_pkg::KIND_SET,     5, 0, 0, lkfr_pkg::STAT_OK,        0, 0},
    '{0, 0, 0, lkfr_pkg::KIND_EVICT,   0, 0, 0, lkfr_pkg::STAT_OK,        0, 0},
    '{0, 0, 0, lkfr_pkg::KIND_SET,     5, 1, 0, lkfr_pkg::STAT_OK,        0, 0},
    '{0, 0, 0, lkfr_pkg::KIND_REMOVE,  5, 0, 0, lkfr_pkg::STAT_OK,        0, 0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  lkfr_req_if req ();
  lkfr_rsp_if rsp ();
  lkfr_cfg_if cfg ();

  lru_k_frame_replacer_unit #(.MAX_FRAMES(NFR)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp),
    .cfg_i  (cfg)
  );

  always #2 clk_i = ~clk_i;

  // Frame table model
  bit                  fr_live  [NFR];
  bit                  fr_evict [NFR];
  logic [HT_W-1:0]     fr_hits  [NFR];
  logic [FRM_W-1:0]    fr_rank  [NFR];
  logic [CNT_W-1:0]    evict_cnt;
  logic [K_W-1:0]      kth_q  = lkfr_pkg::KTH_RST;
  logic [CAP_W-1:0]    hcap_q = lkfr_pkg::HCAP_RST;

  outcome_t pending_q [$];
  int       fails       = 0;
  int       cycles      = 0;
  int       snd_idle    = 20;
  int       rcv_idle    = 75;
  bit       long_hold   = 1'b0;
  int       hold_left   = 0;

  // Make f the most recent frame; live frames newer than f (all of them for a new frame) age by one rank
  function automatic void promote_frame(int f, bit was_live);
    for (int i = 0; i < NFR; i++) begin
      if (i != f && fr_live[i] && (!was_live || fr_rank[i] < fr_rank[f]))
        fr_rank[i]++;
    end
    fr_rank[f] = '0;
  endfunction

  // Forget frame f and close the gap in the ranks
  function automatic void drop_frame(int f);
    for (int i = 0; i < NFR; i++) begin
      if (i != f && fr_live[i] && fr_rank[i] > fr_rank[f])
        fr_rank[i]--;
    end
    fr_live[f]  = 1'b0;
    fr_evict[f] = 1'b0;
    fr_hits[f]  = '0;
    fr_rank[f]  = '0;
    if (evict_cnt != 0)
      evict_cnt--;
  endfunction

  // Least recent evictable frame of one class, -1 if none
  function automatic int oldest_evictable(bit cache_class);
    int best;
    best = -1;
    for (int i = 0; i < NFR; i++) begin
      if (fr_live[i] && fr_evict[i] && ((fr_hits[i] >= kth_q) == cache_class)) begin
        if (best < 0 || fr_rank[i] > fr_rank[best])
          best = i;
      end
    end
    return best;
  endfunction

  // Apply one request to the table and give the result it causes
  function automatic outcome_t replacer_apply(lkfr_pkg::kind_e kind,
                                              logic [FRM_W-1:0] frame, bit flag);
    outcome_t o;
    int       pick;
    int       hist;
    int       f;
    o    = '0;
    f    = int'(frame);
    o.status = lkfr_pkg::STAT_OK;
    case (kind)
      lkfr_pkg::KIND_EVICT: begin
        pick = oldest_evictable(1'b0);
        if (pick < 0)
          pick = oldest_evictable(1'b1);
        if (pick < 0) begin
          o.status = lkfr_pkg::STAT_NONE;
        end else begin
          o.victim = VIC_W'(pick);
          drop_frame(pick);
        end
      end
      lkfr_pkg::KIND_ACCESS: begin
        if (!fr_live[f]) begin
          hist = 0;
          for (int i = 0; i < NFR; i++)
            if (fr_live[i] && fr_hits[i] < kth_q)
              hist++;
          if (hist >= int'(hcap_q)) begin
            o.status = lkfr_pkg::STAT_HIST_FULL;
          end else begin
            promote_frame(f, 1'b0);
            fr_live[f]  = 1'b1;
            fr_evict[f] = 1'b1;
            fr_hits[f]  = HT_W'(1);
            evict_cnt++;
          end
        end else begin
          if (fr_hits[f] != lkfr_pkg::HIT_MAX)
            fr_hits[f]++;
          promote_frame(f, 1'b1);
        end
      end
      lkfr_pkg::KIND_SET: begin
        if (!fr_live[f]) begin
          o.status = lkfr_pkg::STAT_UNKNOWN;
        end else if (fr_evict[f] && !flag) begin
          fr_evict[f] = 1'b0;
          if (evict_cnt != 0)
            evict_cnt--;
        end else if (!fr_evict[f] && flag) begin
          fr_evict[f] = 1'b1;
          evict_cnt++;
        end
      end
      default: begin
        if (fr_live[f]) begin
          if (!fr_evict[f])
            o.status = lkfr_pkg::STAT_NOT_EVICT;
          else
            drop_frame(f);
        end
      end
    endcase
    o.count = evict_cnt;
    return o;
  endfunction

  // Offer one request beat; the model is updated at the accepting edge
  task automatic send_req(lkfr_pkg::kind_e kind, logic [FRM_W-1:0] frame, bit flag,
                          bit fixed, outcome_t typed);
    outcome_t o;
    if ($urandom_range(99) < snd_idle) begin
      req.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle);
    end
    req.valid          <= 1'b1;
    req.kind           <= kind;
    req.frame          <= frame;
    req.evictable_flag <= flag;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    o = replacer_apply(kind, frame, flag);
    pending_q.insert(pending_q.size(), fixed ? typed : o);
  endtask

  // Stop offering and wait for every pending result beat
  task automatic drain();
    req.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  // Write both registers while the block is idle
  task automatic write_regs(logic [K_W-1:0] k_val, logic [CAP_W-1:0] cap_val);
    drain();
    cfg.valid <= 1'b1;
    cfg.index <= lkfr_pkg::CFG_K_THRESHOLD;
    cfg.data  <= lkfr_pkg::CFG_DATA_W'(k_val);
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    kth_q = k_val;
    cfg.index <= lkfr_pkg::CFG_HIST_CAP;
    cfg.data  <= cap_val;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    hcap_q = cap_val;
    cfg.valid <= 1'b0;
  endtask

  // Result side: check beats, drive ready with random and long stalls
  initial begin
    outcome_t want;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp.valid && rsp.ready) begin
        if (pending_q.size() == 0) begin
          $error("result beat with no request pending");
          fails++;
        end else begin
          want = pending_q.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            fails++;
          end
          if (rsp.victim !== want.victim) begin
            $error("victim: expected %0d, got %0d", want.victim, rsp.victim);
            fails++;
          end
          if (rsp.evictable_count !== want.count) begin
            $error("evictable_count: expected %0d, got %0d", want.count,
                   rsp.evictable_count);
            fails++;
          end
        end
      end
      if (long_hold) begin
        long_hold = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  // Watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Stimulus
  initial begin
    lkfr_pkg::kind_e   kind;
    logic [FRM_W-1:0]  frame;
    int                r;
    logic [K_W-1:0]    k_val;
    logic [CAP_W-1:0]  cap_val;

    for (int i = 0; i < NFR; i++) begin
      fr_live[i]  = 1'b0;
      fr_evict[i] = 1'b0;
      fr_hits[i]  = '0;
      fr_rank[i]  = '0;
    end
    evict_cnt = '0;

    rst_ni             <= 1'b0;
    req.valid          <= 1'b0;
    req.kind           <= lkfr_pkg::KIND_ACCESS;
    req.frame          <= '0;
    req.evictable_flag <= 1'b0;
    cfg.valid          <= 1'b0;
    cfg.index          <= lkfr_pkg::CFG_K_THRESHOLD;
    cfg.data           <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed steps
    foreach (PLAN[i]) begin
      if (PLAN[i].wr_regs)
        write_regs(PLAN[i].k_val, PLAN[i].cap_val);
      send_req(PLAN[i].kind, PLAN[i].frame, PLAN[i].flag, PLAN[i].fixed,
               outcome_t'{PLAN[i].st, PLAN[i].vic, PLAN[i].cnt});
    end

    // Random segments, each under its own register setting
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      case (seg)
        0: begin k_val = 4'd2;  cap_val = 5'd16; end
        1: begin k_val = 4'd1;  cap_val = 5'd1;  end
        2: begin k_val = 4'd15; cap_val = 5'd16; end
        3: begin k_val = 4'd3;  cap_val = 5'd4;  end
        4: begin k_val = 4'd0;  cap_val = 5'd0;  end
        5: begin k_val = 4'd4;  cap_val = 5'd2;  end
        6: begin k_val = 4'd15; cap_val = 5'd1;  end
        7: begin
          k_val   = K_W'($urandom_range(15));
          cap_val = CAP_W'($urandom_range(31));
        end
        default: begin k_val = 4'd2; cap_val = 5'd8; end
      endcase
      write_regs(k_val, cap_val);
      case (seg / 3)
        0:       begin snd_idle = 20; rcv_idle = 75; end
        1:       begin snd_idle = 75; rcv_idle = 20; end
        default: begin snd_idle = 0;  rcv_idle = 0;  end
      endcase
      // long receiver stall while requests keep coming
      if (seg == 6)
        long_hold = 1'b1;
      for (int n = 0; n < SEG_ITEMS; n++) begin
        // sender waits for the block to empty out once
        if (seg == 3 && n == SEG_ITEMS / 2)
          drain();
        r = $urandom_range(99);
        if (r < 45)
          kind = lkfr_pkg::KIND_ACCESS;
        else if (r < 65)
          kind = lkfr_pkg::KIND_SET;
        else if (r < 78)
          kind = lkfr_pkg::KIND_REMOVE;
        else
          kind = lkfr_pkg::KIND_EVICT;
        // hot frames collect many accesses
        frame = ($urandom_range(99) < 60) ? FRM_W'($urandom_range(5))
                                          : FRM_W'($urandom_range(NFR - 1));
        send_req(kind, frame, ($urandom_range(99) < 60), 1'b0, '0);
      end
    end

    drain();
    repeat (2 * NFR + 8) @(posedge clk_i);
    if (fails == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/lkfr_pkg.sv
sv/lkfr_if.sv
sv/lkfr_ram.sv
sv/lru_k_frame_replacer_unit.sv
sv/lkfr_checker.sv
tb/tb.sv
